@@ rtl/btwa_pkg.sv @@
// Shared constants for the busy-time window averager: field widths,
// operation codes and parameter defaults. No dependencies.
`default_nettype none

package btwa_pkg;

  localparam int WINDOW_DEPTH_DEF = 64;
  localparam int TICK_BITS_DEF    = 32;

  localparam int NOW_W   = 32;
  localparam int FUNC_W  = 2;
  localparam int AVG_W   = 40;
  localparam int CNT_OUT_W = 7;
  localparam int MC_W    = 7;
  localparam int FRAC_W  = 8;
  localparam int PERIOD_W = 32;
  localparam int MAX_COUNT_RST = 16;

  localparam logic [FUNC_W-1:0] FUNC_START = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_END   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_NEXT  = 2'd2;

endpackage

`default_nettype wire

@@ rtl/btwa_div.sv @@
// Restoring divider, one quotient bit per cycle.
// Self-contained; widths come from the top level.
`default_nettype none

module btwa_div #(
  parameter int DVD_W = 46,
  parameter int DSR_W = 7
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [DVD_W-1:0] dividend,
  input  wire logic [DSR_W-1:0] divisor,
  output logic                  done,
  output logic [DVD_W-1:0]      quotient
);

  localparam int STEP_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0]  work;
  logic [DSR_W-1:0]  rem;
  logic [DSR_W-1:0]  dsr;
  logic [STEP_W-1:0] steps;
  logic              running;

  logic [DSR_W:0]    trial;
  logic              fits;

  always_comb begin
    trial = {rem, work[DVD_W-1]};
    fits  = (trial >= {1'b0, dsr});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      steps   <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        steps   <= STEP_W'(DVD_W);
      end else if (running) begin
        steps <= steps - 1'b1;
        if (steps == STEP_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      work <= dividend;
      rem  <= '0;
      dsr  <= divisor;
    end else if (running) begin
      // shift one dividend bit into the remainder, subtract when it fits
      work <= {work[DVD_W-2:0], fits};
      rem  <= fits ? DSR_W'(trial - {1'b0, dsr}) : DSR_W'(trial);
    end
  end

  assign quotient = work;

endmodule

`default_nettype wire

@@ rtl/busy_time_window_averager_unit.sv @@
// Busy-time window averager, top level.
// Depends on btwa_pkg and btwa_div.
`default_nettype none

// Each input word carries an operation (start, end, next period) and a tick
// timestamp, and produces exactly one output word with the Q32.8 mean of the
// completed periods in the window, the period count and the logging flag.
// Period totals sit in a single-port-read memory of WINDOW_DEPTH entries.
// The block takes one word at a time and accepts no new word until the
// current one is through. An item runs a summing pass that reads one memory
// entry per cycle over the stored periods but the newest, then a bit-serial
// divide of QW bits, where QW = max(40, 40 + log2(depth)). An item that
// closes an open interval while periods are stored first reads and updates
// the newest period (S_RDNEW, S_UPD), and a period step then pushes the new
// period (S_PUSH). With fewer than two periods the sum and divide are
// skipped. A sink stall holds the block in its last state until the output
// register frees up. The result sits in an output register, so the next
// input word is taken while the previous result still waits for the sink.
// max_count is to be written through cfg_we/cfg_wdata only while the block
// is idle; the block itself does not enforce this. Zero is ignored and values
// above the depth clamp to the depth; a smaller value trims the window at the
// next period step.
module busy_time_window_averager_unit
  import btwa_pkg::*;
#(
  parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF,
  parameter int TICK_BITS    = TICK_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // config: max_count
  input  wire logic        cfg_we,
  input  wire logic [6:0]  cfg_wdata,
  // input words
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // [31:0] now
  input  wire logic [1:0]  s_axis_tuser,   // [1:0] func
  // result words
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [47:0]      m_axis_tdata    // [39:0] average, [46:40] period_count,
                                           // [47] logging_on
);

  localparam int AW     = $clog2(WINDOW_DEPTH);
  localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
  localparam int CMP_W  = (CNT_W + 1 > MC_W) ? CNT_W + 1 : MC_W;
  localparam int NOW_B  = (TICK_BITS < NOW_W) ? TICK_BITS : NOW_W;
  localparam int SUM_W  = ((TICK_BITS > PERIOD_W) ? TICK_BITS : PERIOD_W) + 1;
  localparam int ACC_W  = PERIOD_W + AW;
  localparam int QW     = (ACC_W + FRAC_W > AVG_W) ? ACC_W + FRAC_W : AVG_W;
  localparam int MC_RST = (MAX_COUNT_RST > WINDOW_DEPTH) ? WINDOW_DEPTH : MAX_COUNT_RST;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_RDNEW = 8'b0000_0010,
    S_UPD   = 8'b0000_0100,
    S_PUSH  = 8'b0000_1000,
    S_AVG0  = 8'b0001_0000,
    S_SUM   = 8'b0010_0000,
    S_DIV   = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_t;

  state_t state;

  // architectural state
  logic [CNT_W-1:0]     max_count;
  logic                 logging_flag;
  logic [NOW_B-1:0]     interval_start;
  logic [AW-1:0]        newest_slot;
  logic [CNT_W-1:0]     stored_count;

  // period memory
  logic [PERIOD_W-1:0]  period_store [WINDOW_DEPTH];
  logic [PERIOD_W-1:0]  mem_rdata;
  logic                 mem_re;
  logic [AW-1:0]        mem_raddr;
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [PERIOD_W-1:0]  mem_wdata;

  // per-item working registers
  logic [FUNC_W-1:0]    func;
  logic [TICK_BITS-1:0] elapsed;
  logic [AW-1:0]        ptr;
  logic [CNT_W-1:0]     left;
  logic                 rd_pending;
  logic [ACC_W-1:0]     acc;
  logic                 avg_zero;

  // output register
  logic [AVG_W-1:0]     out_avg;
  logic [CNT_OUT_W-1:0] out_cnt;
  logic                 out_log;

  // divider
  logic                 div_start;
  logic                 div_done;
  logic [QW-1:0]        div_q;

  // combinational helpers
  logic [NOW_B-1:0]     now_in;
  logic [TICK_BITS-1:0] diff_in;
  logic [SUM_W-1:0]     sat_sum;
  logic [PERIOD_W-1:0]  sat_val;
  logic [AW-1:0]        newest_inc;
  logic [AW-1:0]        newest_dec;
  logic [AW-1:0]        ptr_dec;
  logic [CMP_W-1:0]     count_inc;
  logic [CNT_W-1:0]     count_new;
  logic                 out_free;

  assign s_axis_tready = (state == S_IDLE);
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  always_comb begin
    now_in  = NOW_B'(s_axis_tdata);
    diff_in = TICK_BITS'(now_in) - TICK_BITS'(interval_start);

    // saturating add of the closed interval into the newest period
    sat_sum = SUM_W'(mem_rdata) + SUM_W'(elapsed);
    sat_val = (sat_sum[SUM_W-1:PERIOD_W] != '0) ? '1 : sat_sum[PERIOD_W-1:0];

    newest_inc = (newest_slot == AW'(WINDOW_DEPTH - 1)) ? '0 : newest_slot + 1'b1;
    newest_dec = (newest_slot == '0) ? AW'(WINDOW_DEPTH - 1) : newest_slot - 1'b1;
    ptr_dec    = (ptr == '0) ? AW'(WINDOW_DEPTH - 1) : ptr - 1'b1;

    // grow the window by one, clamp to depth and to max_count
    count_inc = CMP_W'(stored_count) + 1'b1;
    if (count_inc > CMP_W'(WINDOW_DEPTH)) begin
      count_inc = CMP_W'(WINDOW_DEPTH);
    end
    if (count_inc > CMP_W'(max_count)) begin
      count_inc = CMP_W'(max_count);
    end
    count_new = CNT_W'(count_inc);
  end

  // memory control
  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = ptr;
    mem_we    = 1'b0;
    mem_waddr = newest_slot;
    mem_wdata = sat_val;
    unique case (state)
      S_RDNEW: begin
        mem_re    = 1'b1;
        mem_raddr = newest_slot;
      end
      S_UPD: begin
        mem_we = 1'b1;
      end
      S_PUSH: begin
        mem_we    = 1'b1;
        mem_waddr = newest_inc;
        mem_wdata = '0;
      end
      S_SUM: begin
        mem_re = (left != '0);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      period_store[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata <= period_store[mem_raddr];
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_count <= CNT_W'(MC_RST);
    end else if (cfg_we && cfg_wdata != '0) begin
      if (CMP_W'(cfg_wdata) > CMP_W'(WINDOW_DEPTH)) begin
        max_count <= CNT_W'(WINDOW_DEPTH);
      end else begin
        max_count <= CNT_W'(cfg_wdata);
      end
    end
  end

  assign div_start = (state == S_SUM) && (left == '0) && !rd_pending;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      logging_flag   <= 1'b0;
      interval_start <= '0;
      newest_slot    <= '0;
      stored_count   <= '0;
      m_axis_tvalid  <= 1'b0;
      rd_pending     <= 1'b0;
      left           <= '0;
    end else begin
      // drop valid once the sink takes the word, unless a new one loads now
      if (m_axis_tvalid && m_axis_tready && state != S_DONE) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            func    <= s_axis_tuser;
            elapsed <= diff_in;
            if (s_axis_tuser == FUNC_START) begin
              if (!logging_flag) begin
                logging_flag   <= 1'b1;
                interval_start <= now_in;
              end
              state <= S_AVG0;
            end else if (s_axis_tuser == FUNC_END || s_axis_tuser == FUNC_NEXT) begin
              // close an open interval first; drop its time with no period
              if (logging_flag) begin
                logging_flag <= 1'b0;
              end
              if (logging_flag && stored_count != '0) begin
                state <= S_RDNEW;
              end else if (s_axis_tuser == FUNC_NEXT) begin
                state <= S_PUSH;
              end else begin
                state <= S_AVG0;
              end
            end else begin
              state <= S_AVG0;
            end
          end
        end
        S_RDNEW: begin
          state <= S_UPD;
        end
        S_UPD: begin
          state <= (func == FUNC_NEXT) ? S_PUSH : S_AVG0;
        end
        S_PUSH: begin
          newest_slot  <= newest_inc;
          stored_count <= count_new;
          state        <= S_AVG0;
        end
        S_AVG0: begin
          // walk periods 1..count-1, oldest side reached last
          ptr        <= newest_dec;
          left       <= stored_count - 1'b1;
          rd_pending <= 1'b0;
          acc        <= '0;
          avg_zero   <= (stored_count < CNT_W'(2));
          state      <= (stored_count < CNT_W'(2)) ? S_DONE : S_SUM;
        end
        S_SUM: begin
          if (left != '0) begin
            ptr  <= ptr_dec;
            left <= left - 1'b1;
          end
          rd_pending <= (left != '0);
          if (rd_pending) begin
            acc <= acc + ACC_W'(mem_rdata);
          end
          if (div_start) begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          // hold until the output register is free
          if (out_free) begin
            out_avg       <= avg_zero ? '0 : div_q[AVG_W-1:0];
            out_cnt       <= CNT_OUT_W'(stored_count);
            out_log       <= logging_flag;
            m_axis_tvalid <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  btwa_div #(
    .DVD_W (QW),
    .DSR_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (QW'({acc, {FRAC_W{1'b0}}})),
    .divisor  (stored_count - 1'b1),
    .done     (div_done),
    .quotient (div_q)
  );

  assign m_axis_tdata = {out_log, out_cnt, out_avg};

endmodule

`default_nettype wire

@@ verif/tb_top.sv @@
// Self-checking testbench for busy_time_window_averager_unit.
// Predicts each result word from its own copy of the window state and
// checks the result stream. Depends on btwa_pkg and the RTL top level.
module tb_top;
  import btwa_pkg::*;

  localparam int DEPTH = WINDOW_DEPTH_DEF;
  // Unused operation code: the block must leave its state alone.
  localparam logic [FUNC_W-1:0] FUNC_IDLE = 2'd3;
  // Cycles to let pass after the last result; covers a full-window item.
  localparam int SETTLE_CYCLES = 150;
  localparam int PRINT_CAP = 40;

  typedef struct packed {
    logic [AVG_W-1:0]     average;
    logic [CNT_OUT_W-1:0] count;
    logic                 log_on;
  } busy_report_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_we = 1'b0;
  logic [MC_W-1:0]   cfg_wdata = '0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [NOW_W-1:0]  s_axis_tdata = '0;    // [31:0] now
  logic [FUNC_W-1:0] s_axis_tuser = '0;    // [1:0] func
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [47:0]       m_axis_tdata;         // [39:0] average, [46:40] count, [47] logging

  busy_time_window_averager_unit uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Shadow of the block: open interval, per-period busy totals as a ring
  // indexed from the newest slot, and the window length and cap.
  logic              log_open;
  logic [NOW_W-1:0]  log_since;
  logic [PERIOD_W-1:0] period_busy [DEPTH];
  int                head_slot;
  int                window_len;
  int                window_cap;

  busy_report_t      pending_results[$];
  int                err_count = 0;
  bit                src_quiet = 1'b0;
  bit                sink_quiet = 1'b0;
  logic [NOW_W-1:0]  tick = '0;

  initial begin
    forever #5 clk = ~clk;
  end

  // Sink side: drop ready at random about 9 percent of the time, except during a quiet stretch.
  always @(negedge clk) begin
    m_axis_tready = sink_quiet || ($urandom_range(99) >= 9);
  end

  // ---------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------

  // Close an open interval and credit the elapsed ticks (modulo 2^32) to the
  // newest period, saturating. With an empty window the time is dropped.
  function automatic void close_interval(logic [NOW_W-1:0] now);
    logic [PERIOD_W:0] total;
    if (!log_open) return;
    log_open = 1'b0;
    if (window_len > 0) begin
      total = {1'b0, period_busy[head_slot]} + {1'b0, now - log_since};
      period_busy[head_slot] = total[PERIOD_W] ? '1 : total[PERIOD_W-1:0];
    end
  endfunction

  // Mean of every stored period but the newest, Q32.8, truncated.
  function automatic logic [AVG_W-1:0] window_mean_q8();
    logic [63:0] acc;
    acc = '0;
    if (window_len < 2) return '0;
    for (int i = 1; i < window_len; i++) begin
      acc += period_busy[(head_slot + DEPTH - i) % DEPTH];
    end
    acc = (acc << FRAC_W) / (window_len - 1);
    return acc[AVG_W-1:0];
  endfunction

  function automatic busy_report_t apply_op(logic [FUNC_W-1:0] func, logic [NOW_W-1:0] now);
    busy_report_t r;
    case (func)
      FUNC_START: begin
        // a start while logging keeps the original interval start
        if (!log_open) begin
          log_open = 1'b1;
          log_since = now;
        end
      end
      FUNC_END: close_interval(now);
      FUNC_NEXT: begin
        close_interval(now);
        head_slot = (head_slot + 1) % DEPTH;
        period_busy[head_slot] = '0;
        window_len = window_len + 1;
        if (window_len > DEPTH) window_len = DEPTH;
        // a lowered cap trims here, not at the register write
        if (window_len > window_cap) window_len = window_cap;
      end
      default: ;
    endcase
    r.average = window_mean_q8();
    r.count   = window_len[CNT_OUT_W-1:0];
    r.log_on  = log_open;
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    err_count++;
    if (err_count <= PRINT_CAP)
      $display("MISMATCH %s: got 0x%0h want 0x%0h at %0t", what, got, want, $time);
  endtask

  // Compare each accepted result word against the oldest prediction.
  always @(posedge clk) begin : result_check
    busy_report_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result word with nothing pending", m_axis_tdata, '0);
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata[AVG_W-1:0] !== want.average)
          report_mismatch("average", m_axis_tdata[AVG_W-1:0], want.average);
        if (m_axis_tdata[AVG_W+CNT_OUT_W-1:AVG_W] !== want.count)
          report_mismatch("period_count", m_axis_tdata[AVG_W+CNT_OUT_W-1:AVG_W], want.count);
        if (m_axis_tdata[AVG_W+CNT_OUT_W] !== want.log_on)
          report_mismatch("logging_on", m_axis_tdata[AVG_W+CNT_OUT_W], want.log_on);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------

  // Send one input word. Idle first now and then (valid low, junk data) so
  // gaps land both while the block is busy and while it waits for input.
  // Valid stays high from one word to the next when there is no gap.
  task automatic send_word(logic [FUNC_W-1:0] func, logic [NOW_W-1:0] now);
    int gap;
    gap = 0;
    if (!src_quiet && $urandom_range(99) < 9) gap = $urandom_range(130, 1);
    if (gap != 0) begin
      @(negedge clk);
      s_axis_tvalid = 1'b0;
      s_axis_tdata  = $urandom;
      s_axis_tuser  = FUNC_W'($urandom);
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = now;
    s_axis_tuser  = func;
    do @(posedge clk); while (!s_axis_tready);
    pending_results.push_back(apply_op(func, now));
  endtask

  // Hold off input until every predicted result word has been seen.
  task automatic drain_results();
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Write max_count with the block idle. Zero is ignored, values above the
  // depth clamp to the depth.
  task automatic write_window_cap(logic [MC_W-1:0] value);
    drain_results();
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we    = 1'b0;
    cfg_wdata = MC_W'($urandom);
    if (value != 0) window_cap = (value > DEPTH) ? DEPTH : value;
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Corner cases of the logging flag and the empty window.
  task automatic test_special_cases();
    send_word(FUNC_IDLE, 32'h0000_0000);   // unused code straight out of reset
    send_word(FUNC_END, 32'h0000_0050);    // end while not logging
    send_word(FUNC_START, 32'd100);
    send_word(FUNC_START, 32'd200);        // start while logging: keep 100
    send_word(FUNC_END, 32'd300);          // no period yet: time dropped
    send_word(FUNC_NEXT, 32'h0000_0000);   // first period
    send_word(FUNC_START, 32'hFFFF_FFF0);
    send_word(FUNC_END, 32'h0000_0010);    // wraps: 0x20 ticks
    send_word(FUNC_NEXT, 32'h0000_0000);   // two periods: first mean
  endtask

  // Period totals at and past the 32-bit limit.
  task automatic test_saturation();
    send_word(FUNC_START, 32'h0000_0000);
    send_word(FUNC_NEXT, 32'hFFFF_FFFF);   // step closes the interval
    send_word(FUNC_START, 32'h0000_0000);
    send_word(FUNC_END, 32'h8000_0000);
    send_word(FUNC_START, 32'h0000_0000);
    send_word(FUNC_END, 32'hFFFF_FFFF);    // saturates
    send_word(FUNC_NEXT, 32'h1234_5678);
  endtask

  // Register extremes: zero ignored, 1, above the depth, and trim on step.
  task automatic test_window_cap();
    write_window_cap(7'd0);
    send_word(FUNC_NEXT, 32'h0000_0001);   // cap still 16
    write_window_cap(7'd1);
    send_word(FUNC_NEXT, 32'h0000_0002);   // trims to one period
    send_word(FUNC_NEXT, 32'h0000_0003);
    write_window_cap(7'd127);              // clamps to the depth
    send_word(FUNC_START, 32'd5);
    send_word(FUNC_NEXT, 32'd9);
    write_window_cap(7'd65);
    send_word(FUNC_NEXT, 32'd9);
  endtask

  // Mostly well-formed logging sessions with random timing; a few unused
  // codes, stray starts and stray ends mixed in.
  task automatic run_random_phase(int items);
    int r;
    logic [FUNC_W-1:0] func;
    for (int n = 0; n < items; n++) begin
      r = $urandom_range(99);
      if (r < 4)
        func = FUNC_IDLE;
      else if (!log_open)
        func = (r < 72) ? FUNC_START : (r < 92) ? FUNC_NEXT : FUNC_END;
      else
        func = (r < 60) ? FUNC_END : (r < 88) ? FUNC_NEXT : FUNC_START;
      // advance the tick counter: mostly short steps, some huge ones that
      // wrap or push a period toward saturation, some jumps anywhere
      r = $urandom_range(99);
      if (r < 6)
        tick = $urandom;
      else if (r < 16)
        tick = tick + $urandom;
      else if (r < 22)
        tick = tick;
      else
        tick = tick + $urandom_range(5000);
      send_word(func, tick);
    end
  endtask

  task automatic test_random_sessions();
    logic [MC_W-1:0] caps [8];
    caps = '{7'd64, 7'd2, 7'd1, 7'd127, 7'd0, 7'd9, 7'd33, 7'd16};
    caps[6] = MC_W'($urandom_range(127));
    for (int p = 0; p < 8; p++) begin
      write_window_cap(caps[p]);
      // one phase runs with no idling on either side
      src_quiet  = (p == 3);
      sink_quiet = (p == 3);
      run_random_phase(230);
    end
    src_quiet  = 1'b0;
    sink_quiet = 1'b0;
  endtask

  // ---------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------

  initial begin
    log_open   = 1'b0;
    log_since  = '0;
    head_slot  = 0;
    window_len = 0;
    window_cap = MAX_COUNT_RST;
    for (int i = 0; i < DEPTH; i++) period_busy[i] = '0;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_special_cases();
    test_saturation();
    test_window_cap();
    test_random_sessions();

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (err_count == 0 && pending_results.size() == 0) begin
      $display("busy_time_window_averager_unit verification clean");
    end else begin
      $display("busy_time_window_averager_unit verification failed");
    end
    $finish;
  end

  // Hard stop well past the slowest correct run.
  initial begin
    #50_000_000;
    $display("busy_time_window_averager_unit verification failed");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/btwa_pkg.sv
rtl/btwa_div.sv
rtl/busy_time_window_averager_unit.sv
verif/tb_top.sv
